>>> sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/ateg_pkg.sv
// shared types, widths and codes of the absolute touch event generator
package ateg_pkg;

  localparam int COORD_W  = 16;
  localparam int BUTTON_W = 32;
  localparam int MOD_W    = 8;
  localparam int NORM_W   = 15;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W = 2;

  // quotient bits produced by the serial divider
  localparam int DIV_STEPS = 16;

  localparam int unsigned NORM_RANGE_DEF = 32768;
  localparam logic [NORM_W-1:0] NORM_MAX = '1;

  // event codes
  typedef enum logic [KIND_W-1:0] {
    KIND_DOWN = 2'd0,
    KIND_UP   = 2'd1,
    KIND_MOVE = 2'd2
  } kind_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = 2'd3;

  // request to the shared scaling unit
  typedef struct packed {
    logic               start;
    logic [COORD_W-1:0] value;
    logic [COORD_W-1:0] lo;
    logic [COORD_W-1:0] hi;
  } scale_req_t;

  // response from the shared scaling unit
  typedef struct packed {
    logic              done;
    logic [NORM_W-1:0] norm;
  } scale_rsp_t;

endpackage

>>> sv/absolute_touch_event_generator.sv
// top level: report decoding, contact state and event sequencer
//
//  channel | valid / ready         | payload
//  --------+-----------------------+-----------------------------------------------
//  report  | req_valid / req_ready | cur_x, cur_y, active_buttons, key_modifiers
//  event   | evt_valid / evt_ready | event_kind, norm_x, norm_y, event_buttons,
//          |                       | event_modifiers
//  config  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A report that raises no event is taken and ready stays high.
// A report that raises an event holds ready low while each axis goes through
// the shared scaling unit (load, multiply, 16 divide steps), X first, then Y.
// A finished event waits in the output register; a new report is taken while
// it waits, and the next event leaves only after the waiting one is taken.
// Reset clears the contact flag and the stored position and opens the window
// registers to the full coordinate range.
module absolute_touch_event_generator #(
  parameter int unsigned NORM_RANGE = ateg_pkg::NORM_RANGE_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  logic [ateg_pkg::COORD_W-1:0]       cur_x,
  input  logic [ateg_pkg::COORD_W-1:0]       cur_y,
  input  logic [ateg_pkg::BUTTON_W-1:0]      active_buttons,
  input  logic [ateg_pkg::MOD_W-1:0]         key_modifiers,
  output logic                               evt_valid,
  input  logic                               evt_ready,
  output logic [ateg_pkg::KIND_W-1:0]        event_kind,
  output logic [ateg_pkg::NORM_W-1:0]        norm_x,
  output logic [ateg_pkg::NORM_W-1:0]        norm_y,
  output logic [ateg_pkg::BUTTON_W-1:0]      event_buttons,
  output logic [ateg_pkg::MOD_W-1:0]         event_modifiers,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ateg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ateg_pkg::COORD_W-1:0]       cfg_data
);

  localparam int CW = ateg_pkg::COORD_W;
  localparam int NW = ateg_pkg::NORM_W;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_SCALE_X = 4'b0010,
    ST_SCALE_Y = 4'b0100,
    ST_DONE    = 4'b1000
  } seq_state_t;

  seq_state_t state;
  logic       launch;

  // window registers
  logic [CW-1:0] min_x;
  logic [CW-1:0] max_x;
  logic [CW-1:0] min_y;
  logic [CW-1:0] max_y;

  // contact state
  logic          contact_on;
  logic [CW-1:0] last_x;
  logic [CW-1:0] last_y;

  // event being built
  ateg_pkg::kind_t              work_kind;
  logic [CW-1:0]                work_x;
  logic [CW-1:0]                work_y;
  logic [ateg_pkg::BUTTON_W-1:0] work_buttons;
  logic [ateg_pkg::MOD_W-1:0]   work_mods;
  logic [NW-1:0]                work_nx;
  logic [NW-1:0]                work_ny;

  ateg_pkg::scale_req_t scale_req;
  ateg_pkg::scale_rsp_t scale_rsp;

  logic accept;
  logic active;
  logic is_down;
  logic is_up;
  logic is_move;
  logic out_free;

  assign req_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = req_valid && req_ready;
  assign out_free  = !evt_valid || evt_ready;

  // classify the report against the contact state
  always_comb begin
    active  = (active_buttons != '0);
    is_down = active && !contact_on;
    is_up   = !active && contact_on;
    is_move = !is_down && !is_up && ((cur_x != last_x) || (cur_y != last_y));
  end

  // operands for the shared unit
  always_comb begin
    scale_req.start = launch;
    if (state == ST_SCALE_Y) begin
      scale_req.value = work_y;
      scale_req.lo    = min_y;
      scale_req.hi    = max_y;
    end else begin
      scale_req.value = work_x;
      scale_req.lo    = min_x;
      scale_req.hi    = max_x;
    end
  end

  ateg_scale_unit #(
    .NORM_RANGE (NORM_RANGE)
  ) u_scale (
    .clk (clk),
    .rst (rst),
    .req (scale_req),
    .rsp (scale_rsp)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_x <= '0;
      max_x <= '1;
      min_y <= '0;
      max_y <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ateg_pkg::CFG_MIN_X: min_x <= cfg_data;
        ateg_pkg::CFG_MAX_X: max_x <= cfg_data;
        ateg_pkg::CFG_MIN_Y: min_y <= cfg_data;
        ateg_pkg::CFG_MAX_Y: max_y <= cfg_data;
        default: min_x <= min_x;
      endcase
    end
  end

  // sequencer, contact state and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      launch     <= 1'b0;
      evt_valid  <= 1'b0;
      contact_on <= 1'b0;
      last_x     <= '0;
      last_y     <= '0;
    end else begin
      // start the unit for X on an eventful report, for Y when X is done
      launch <= (accept && (is_down || is_up || is_move)) ||
                ((state == ST_SCALE_X) && scale_rsp.done);
      // output valid set on handover, cleared when taken
      if ((state == ST_DONE) && out_free) begin
        evt_valid <= 1'b1;
      end else if (evt_ready) begin
        evt_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && (is_down || is_up || is_move)) begin
            state <= ST_SCALE_X;
            if (is_up) begin
              contact_on <= 1'b0;
            end else begin
              contact_on <= contact_on || is_down;
              last_x     <= cur_x;
              last_y     <= cur_y;
            end
          end
        end
        ST_SCALE_X: begin
          if (scale_rsp.done) begin
            state <= ST_SCALE_Y;
          end
        end
        ST_SCALE_Y: begin
          if (scale_rsp.done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // event payload
  always_ff @(posedge clk) begin
    if (accept) begin
      work_mods <= key_modifiers;
      if (is_down) begin
        work_kind    <= ateg_pkg::KIND_DOWN;
        work_x       <= cur_x;
        work_y       <= cur_y;
        work_buttons <= active_buttons;
      end else if (is_up) begin
        work_kind    <= ateg_pkg::KIND_UP;
        work_x       <= last_x;
        work_y       <= last_y;
        work_buttons <= '0;
      end else begin
        work_kind    <= ateg_pkg::KIND_MOVE;
        work_x       <= cur_x;
        work_y       <= cur_y;
        work_buttons <= active_buttons;
      end
    end
    if ((state == ST_SCALE_X) && scale_rsp.done) begin
      work_nx <= scale_rsp.norm;
    end
    if ((state == ST_SCALE_Y) && scale_rsp.done) begin
      work_ny <= scale_rsp.norm;
    end
    if ((state == ST_DONE) && out_free) begin
      event_kind      <= work_kind;
      norm_x          <= work_nx;
      norm_y          <= work_ny;
      event_buttons   <= work_buttons;
      event_modifiers <= work_mods;
    end
  end

endmodule

>>> sv/ateg_scale_unit.sv
// shared clamp, multiply and serial divide unit for one coordinate
module ateg_scale_unit #(
  parameter int unsigned NORM_RANGE = ateg_pkg::NORM_RANGE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ateg_pkg::scale_req_t req,
  output ateg_pkg::scale_rsp_t rsp
);

  localparam int CW    = ateg_pkg::COORD_W;
  localparam int PW    = 2 * CW;
  localparam int NW    = ateg_pkg::NORM_W;
  localparam int StepW = $clog2(ateg_pkg::DIV_STEPS);
  localparam logic [CW-1:0]    MulK     = CW'(NORM_RANGE - 1);
  localparam logic [StepW-1:0] LastStep = StepW'(ateg_pkg::DIV_STEPS - 1);

  typedef enum logic [2:0] {
    U_IDLE = 3'b001,
    U_MUL  = 3'b010,
    U_DIV  = 3'b100
  } unit_state_t;

  unit_state_t      ustate;
  logic [CW-1:0]    diff;
  logic [CW-1:0]    den;
  logic             degen;
  logic [CW-1:0]    rem;
  logic [CW-1:0]    quo;
  logic [StepW-1:0] cnt;
  logic             done;
  logic [NW-1:0]    norm;

  logic [CW-1:0] clamped;
  logic [PW-1:0] product;
  logic [CW:0]   trial;
  logic          fits;
  logic [CW-1:0] rem_next;
  logic [CW-1:0] quo_next;
  logic [NW-1:0] norm_next;

  // clamp the coordinate into the configured window
  always_comb begin
    if (req.value < req.lo) begin
      clamped = req.lo;
    end else if (req.value > req.hi) begin
      clamped = req.hi;
    end else begin
      clamped = req.value;
    end
  end

  // scale numerator
  assign product = PW'(diff) * PW'(MulK);

  // one restoring divide step
  always_comb begin
    trial    = {rem, quo[CW-1]};
    fits     = (trial >= {1'b0, den});
    rem_next = fits ? CW'(trial - {1'b0, den}) : trial[CW-1:0];
    quo_next = {quo[CW-2:0], fits};
  end

  // saturate the final quotient, zero for an empty window
  always_comb begin
    if (degen) begin
      norm_next = '0;
    end else if (quo_next[CW-1:NW] != '0) begin
      norm_next = ateg_pkg::NORM_MAX;
    end else begin
      norm_next = quo_next[NW-1:0];
    end
  end

  // sequencer of the unit
  always_ff @(posedge clk) begin
    if (rst) begin
      ustate <= U_IDLE;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      // done pulses for one cycle after the last divide step
      done <= (ustate == U_DIV) && (cnt == LastStep);
      case (ustate)
        U_IDLE: begin
          if (req.start) begin
            ustate <= U_MUL;
          end
        end
        U_MUL: begin
          cnt    <= '0;
          ustate <= U_DIV;
        end
        U_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == LastStep) begin
            ustate <= U_IDLE;
          end
        end
        default: begin
          ustate <= U_IDLE;
        end
      endcase
    end
  end

  // operand and quotient datapath
  always_ff @(posedge clk) begin
    case (ustate)
      U_IDLE: begin
        if (req.start) begin
          diff  <= clamped - req.lo;
          den   <= req.hi - req.lo;
          degen <= (req.hi <= req.lo);
        end
      end
      U_MUL: begin
        rem <= product[PW-1:CW];
        quo <= product[CW-1:0];
      end
      U_DIV: begin
        rem <= rem_next;
        quo <= quo_next;
        if (cnt == LastStep) begin
          norm <= norm_next;
        end
      end
      default: begin
        rem <= rem;
      end
    endcase
  end

  assign rsp.done = done;
  assign rsp.norm = norm;

endmodule

>>> sv/ateg_checker.sv
// port-level checks of the absolute touch event generator, bound to the top
`include "assert_macros.svh"

module ateg_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic [ateg_pkg::COORD_W-1:0]   cur_x,
  input logic [ateg_pkg::COORD_W-1:0]   cur_y,
  input logic [ateg_pkg::BUTTON_W-1:0]  active_buttons,
  input logic [ateg_pkg::MOD_W-1:0]     key_modifiers,
  input logic                           evt_valid,
  input logic                           evt_ready,
  input logic [ateg_pkg::KIND_W-1:0]    event_kind,
  input logic [ateg_pkg::NORM_W-1:0]    norm_x,
  input logic [ateg_pkg::NORM_W-1:0]    norm_y,
  input logic [ateg_pkg::BUTTON_W-1:0]  event_buttons,
  input logic [ateg_pkg::MOD_W-1:0]     event_modifiers,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [ateg_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [ateg_pkg::COORD_W-1:0]   cfg_data
);

  // only the three defined event codes leave the block
  `ASSERT_CLK(a_kind_legal, clk, rst, evt_valid |-> (event_kind == ateg_pkg::KIND_DOWN || event_kind == ateg_pkg::KIND_UP || event_kind == ateg_pkg::KIND_MOVE), "undefined event kind")

  // a lift carries no buttons
  `ASSERT_CLK(a_up_no_buttons, clk, rst, (evt_valid && event_kind == ateg_pkg::KIND_UP) |-> (event_buttons == '0), "touch up with buttons set")

  // a press carries at least one button
  `ASSERT_CLK(a_down_has_buttons, clk, rst, (evt_valid && event_kind == ateg_pkg::KIND_DOWN) |-> (event_buttons != '0), "touch down without buttons")

  // a waiting event holds its kind, position and buttons
  `ASSERT_CLK(a_evt_hold, clk, rst, (evt_valid && !evt_ready) |=> (evt_valid && $stable(event_kind) && $stable(norm_x) && $stable(norm_y) && $stable(event_buttons)), "event changed while stalled")

endmodule

bind absolute_touch_event_generator ateg_checker u_ateg_checker (.*);
